// ===== design/stfd_pkg.sv =====
// Shared types and constants for the stereo feedback delay.
// Used by stfd_chan and stereo_feedback_delay_top; depends on nothing.
package stfd_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned FB_W     = 15;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned PROD_W   = 33;

  localparam logic [GAIN_W-1:0] UNITY_Q15 = 16'd32768;

  // Register indexes of the configuration port
  localparam logic [IDX_W-1:0] CFG_DELAY    = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FEEDBACK = 2'd1;
  localparam logic [IDX_W-1:0] CFG_WET      = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
  } out_t;

  // Pipeline control from the top level to each channel datapath
  typedef struct packed {
    logic issue;      // item enters the read stage
    logic load;       // read stage item moves to the output register
    logic fwd_hit;    // read stage takes the bypassed sample
    logic unwritten;  // read stage entry never written since reset
  } chan_ctrl_t;

endpackage

// ===== design/stfd_ram.sv =====
// Simple dual-port delay store: one write and one registered read per cycle.
// Read returns the old contents on a same-address write. No package use.
module stfd_ram #(
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= store_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/stfd_chan.sv =====
// One channel of the echo datapath: feedback value, mix products, output rounding.
// Depends on stfd_pkg for widths and the control struct.
module stfd_chan (
  input  logic                                clk_i,
  input  stfd_pkg::chan_ctrl_t                ctrl_i,
  input  logic signed [stfd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic signed [stfd_pkg::SAMPLE_W-1:0] rdata_i,
  input  logic [stfd_pkg::FB_W-1:0]           fb_gain_i,
  input  logic [stfd_pkg::GAIN_W-1:0]         wet_i,
  input  logic [stfd_pkg::GAIN_W-1:0]         dry_i,
  output logic signed [stfd_pkg::SAMPLE_W-1:0] wdata_o,
  output logic signed [stfd_pkg::SAMPLE_W-1:0] out_o
);
  import stfd_pkg::*;

  // Add half an LSB, floor shift by 15, clamp to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [PROD_W:0] v);
    logic signed [PROD_W:0]        t;
    logic signed [PROD_W-15:0]     r;
    t = v + (PROD_W+1)'(16384);
    r = t[PROD_W:15];
    if (r > (PROD_W-14)'(32767)) begin
      round_sat = 16'sh7fff;
    end else if (r < -(PROD_W-14)'(32768)) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = r[SAMPLE_W-1:0];
    end
  endfunction

  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] byp_q;
  logic signed [SAMPLE_W-1:0] delayed;
  logic signed [SAMPLE_W:0]   fb_s;
  logic signed [SAMPLE_W:0]   wet_s;
  logic signed [SAMPLE_W:0]   dry_s;
  logic signed [PROD_W-1:0]   fb_prod;
  logic signed [SAMPLE_W-1:0] echo;
  logic signed [SAMPLE_W:0]   sum_st;
  logic signed [PROD_W-1:0]   dry_prod_d, dry_prod_q;
  logic signed [PROD_W-1:0]   wet_prod_d, wet_prod_q;
  logic signed [PROD_W:0]     mix_sum;

  assign fb_s  = {2'b00, fb_gain_i};
  assign wet_s = {1'b0, wet_i};
  assign dry_s = {1'b0, dry_i};

  // Bypass beats the memory, an entry never written reads as silence
  always_comb begin
    if (ctrl_i.fwd_hit) begin
      delayed = byp_q;
    end else if (ctrl_i.unwritten) begin
      delayed = '0;
    end else begin
      delayed = rdata_i;
    end
  end

  assign fb_prod = delayed * fb_s;
  assign echo    = round_sat((PROD_W+1)'(fb_prod));
  assign sum_st  = (SAMPLE_W+1)'(sample_q) + (SAMPLE_W+1)'(echo);

  always_comb begin
    if (sum_st > 17'sd32767) begin
      wdata_o = 16'sh7fff;
    end else if (sum_st < -17'sd32768) begin
      wdata_o = 16'sh8000;
    end else begin
      wdata_o = sum_st[SAMPLE_W-1:0];
    end
  end

  assign dry_prod_d = sample_q * dry_s;
  assign wet_prod_d = delayed * wet_s;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      sample_q <= sample_i;
      byp_q    <= wdata_o;
    end
    if (ctrl_i.load) begin
      dry_prod_q <= dry_prod_d;
      wet_prod_q <= wet_prod_d;
    end
  end

  assign mix_sum = (PROD_W+1)'(dry_prod_q) + (PROD_W+1)'(wet_prod_q);
  assign out_o   = round_sat(mix_sum);

endmodule

// ===== design/stereo_feedback_delay_top.sv =====
// Stereo feedback delay (echo) over two circular sample stores.
// out_valid_o rises when an item moves from the read stage to the output register.
// Throughput: one item per cycle unless the output stalls; the feedback loop
// (delayed sample, multiply, round, add, bypass register) closes in the read stage.
// Reset: config returns to delay 1, no feedback, fully dry; stores are not swept,
// entries not yet written since reset read as zero (no clearing pass).
module stereo_feedback_delay_top #(
  parameter int unsigned DELAY_DEPTH = 131072
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  stfd_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output stfd_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [stfd_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [stfd_pkg::CFG_W-1:0]     cfg_data_i
);
  import stfd_pkg::*;

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned CW = (AW > CFG_W) ? AW : CFG_W;

  // Configuration registers
  logic [CFG_W-1:0]  delay_q;
  logic [FB_W-1:0]   fb_q;
  logic [GAIN_W-1:0] wet_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= CFG_W'(1);
      fb_q    <= '0;
      wet_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DELAY:    delay_q <= cfg_data_i;
        CFG_FEEDBACK: fb_q    <= cfg_data_i[FB_W-1:0];
        CFG_WET:      wet_q   <= cfg_data_i[GAIN_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Clamp delay to 1 .. depth-1, wet share to unity
  logic [CW-1:0]     delay_ext;
  logic [CW-1:0]     delay_clamped;
  logic [AW-1:0]     dly;
  logic [GAIN_W-1:0] wet_eff;
  logic [GAIN_W-1:0] dry_eff;

  assign delay_ext = CW'(delay_q);

  always_comb begin
    if (delay_ext == '0) begin
      delay_clamped = CW'(1);
    end else if (delay_ext > CW'(DELAY_DEPTH - 1)) begin
      delay_clamped = CW'(DELAY_DEPTH - 1);
    end else begin
      delay_clamped = delay_ext;
    end
  end

  assign dly     = delay_clamped[AW-1:0];
  assign wet_eff = (wet_q > UNITY_Q15) ? UNITY_Q15 : wet_q;
  assign dry_eff = UNITY_Q15 - wet_eff;

  // Pipeline control: read stage (s1) and output register (s2)
  logic          s1_valid_q;
  logic          s2_valid_q;
  logic          adv1;
  logic          accept;
  logic [AW-1:0] wr_q;        // position of the next accepted item
  logic          wrapped_q;   // every position has been given to an accepted item
  logic [AW-1:0] s1_wr_q;     // write position of the read stage item
  logic          s1_fwd_q;
  logic          s1_unw_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_next;
  logic          wr_last;
  logic          rd_unwritten;
  logic          fwd_hit;

  assign adv1       = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv1;
  assign accept     = in_valid_i && !in_stall_o;

  // Read position trails the write position by the delay, modulo depth
  always_comb begin
    if (wr_q >= dly) begin
      rd_addr = wr_q - dly;
    end else begin
      rd_addr = AW'((AW+1)'(wr_q) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(dly));
    end
  end

  assign wr_last      = (wr_q == AW'(DELAY_DEPTH - 1));
  assign wr_next      = wr_last ? '0 : wr_q + AW'(1);
  // Writes fill upward from zero, so only entries below wr_q hold data before wrap
  assign rd_unwritten = !wrapped_q && (rd_addr >= wr_q);
  // The item leaving s1 writes at this very edge; capture its value instead
  assign fwd_hit      = s1_valid_q && (s1_wr_q == rd_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      wr_q       <= '0;
      wrapped_q  <= 1'b0;
      s1_fwd_q   <= 1'b0;
      s1_unw_q   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        wr_q       <= wr_next;
        s1_fwd_q   <= fwd_hit;
        s1_unw_q   <= rd_unwritten;
        if (wr_last) begin
          wrapped_q <= 1'b1;
        end
      end else if (adv1) begin
        s1_valid_q <= 1'b0;
      end
      if (adv1) begin
        s2_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_wr_q <= wr_q;
    end
  end

  chan_ctrl_t ctrl;

  assign ctrl.issue     = accept;
  assign ctrl.load      = adv1;
  assign ctrl.fwd_hit   = s1_fwd_q;
  assign ctrl.unwritten = s1_unw_q;

  // Left channel
  logic signed [SAMPLE_W-1:0] left_rdata;
  logic signed [SAMPLE_W-1:0] left_wdata;

  stfd_ram #(
    .DEPTH (DELAY_DEPTH),
    .WIDTH (SAMPLE_W)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (s1_wr_q),
    .wdata_i (left_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (left_rdata)
  );

  stfd_chan u_left_chan (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .sample_i  (in_data_i.sample_left),
    .rdata_i   (left_rdata),
    .fb_gain_i (fb_q),
    .wet_i     (wet_eff),
    .dry_i     (dry_eff),
    .wdata_o   (left_wdata),
    .out_o     (out_data_o.out_left)
  );

  // Right channel
  logic signed [SAMPLE_W-1:0] right_rdata;
  logic signed [SAMPLE_W-1:0] right_wdata;

  stfd_ram #(
    .DEPTH (DELAY_DEPTH),
    .WIDTH (SAMPLE_W)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (s1_wr_q),
    .wdata_i (right_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (right_rdata)
  );

  stfd_chan u_right_chan (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .sample_i  (in_data_i.sample_right),
    .rdata_i   (right_rdata),
    .fb_gain_i (fb_q),
    .wet_i     (wet_eff),
    .dry_i     (dry_eff),
    .wdata_o   (right_wdata),
    .out_o     (out_data_o.out_right)
  );

  assign out_valid_o = s2_valid_q;

  // The read never lands on the entry about to be written
  a_rd_not_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> rd_addr != wr_q)
    else $error("read address equals write position");

  // A same-edge write to the read entry must be bypassed
  a_fwd_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s1_valid_q && (s1_wr_q == rd_addr) |=> s1_fwd_q)
    else $error("missed forwarding of in-flight write");

  // A full pipeline under output stall takes no new item
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_valid_q && out_stall_i |-> in_stall_o)
    else $error("input taken while pipeline is blocked");

  // A held read stage keeps its write position
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv1 |=> s1_valid_q && $stable(s1_wr_q))
    else $error("read stage item lost while held");

  // An unwritten read only happens before the first wrap
  a_unw_prewrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_unw_q |-> !wrapped_q)
    else $error("unwritten entry flagged after wrap");

endmodule
